FILE: design/mpf_pkg.sv
package mpf_pkg;

   // Widest word any instance may use
   localparam int MAX_W = 32;

   // Modulus after reset
   localparam int MOD_RESET = 65521;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_SUBTRACT = 3'd1,
      OP_MULTIPLY = 3'd2,
      OP_DIVIDE   = 3'd3,
      OP_NEGATE   = 3'd4,
      OP_INVERSE  = 3'd5,
      OP_EQUAL    = 3'd6
   } opcode_type;

   // Fold a value below twice the modulus back below the modulus
   function automatic logic [MAX_W:0] fold(input logic [MAX_W:0] value,
                                           input logic [MAX_W:0] modulus);
      logic [MAX_W:0] folded;
      folded = (value >= modulus) ? value - modulus : value;
      return folded;
   endfunction

endpackage

FILE: design/mpf_reduce.sv
module mpf_reduce import mpf_pkg::*; #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] value,
   input  logic [W-1:0] modulus,
   output logic         done,
   output logic [W-1:0] result
);

   localparam int CW = $clog2(W);

   logic         run_ff, run_in;
   logic         done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0] shift_ff, shift_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W:0]   widened;
   logic [W-1:0] step;

   // Shift in one dividend bit, msb first, and fold below the modulus
   assign widened = {acc_ff, shift_ff[W-1]};
   assign step = W'(fold((MAX_W+1)'(widened), (MAX_W+1)'(modulus)));

   always_comb begin
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      if (start) begin
         run_in   = 1'b1;
         cnt_in   = CW'(W - 1);
         shift_in = value;
         acc_in   = '0;
      end else if (run_ff) begin
         acc_in   = step;
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

FILE: design/mpf_mul.sv
module mpf_mul import mpf_pkg::*; #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] multiplier,
   input  logic [W-1:0] multiplicand,
   input  logic [W-1:0] modulus,
   output logic         done,
   output logic [W-1:0] result
);

   localparam int CW = $clog2(W);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic          phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  m_ff, m_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  addend;
   logic [W-1:0]  step;

   // Phase zero doubles the accumulator, phase one adds the multiplicand
   // when the current multiplier bit is set; one shared adder and fold
   assign addend = phase_ff ? (x_ff[W-1] ? m_ff : '0) : acc_ff;
   assign step = W'(fold((MAX_W+1)'(acc_ff) + (MAX_W+1)'(addend),
                         (MAX_W+1)'(modulus)));

   always_comb begin
      run_in   = run_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      m_in     = m_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      if (start) begin
         run_in   = 1'b1;
         phase_in = 1'b0;
         cnt_in   = CW'(W - 1);
         x_in     = multiplier;
         m_in     = multiplicand;
         acc_in   = '0;
      end else if (run_ff) begin
         acc_in   = step;
         phase_in = ~phase_ff;
         if (phase_ff) begin
            x_in   = x_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      x_ff     <= x_in;
      m_ff     <= m_in;
      acc_ff   <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

FILE: design/mpf_inv.sv
module mpf_inv #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] operand,
   input  logic [W-1:0] modulus,
   output logic         done,
   output logic [W-1:0] result
);

   logic         run_ff, run_in;
   logic         done_ff, done_in;
   logic [W-1:0] r0_ff, r0_in;
   logic [W-1:0] r1_ff, r1_in;
   logic [W-1:0] t0_ff, t0_in;
   logic [W-1:0] t1_ff, t1_in;
   logic [W-1:0] res_ff, res_in;
   logic [W-1:0] t_diff;

   // Coefficient difference kept below the modulus
   assign t_diff = (t0_ff >= t1_ff) ? t0_ff - t1_ff :
                   W'((W+1)'(t0_ff) + (W+1)'(modulus) - (W+1)'(t1_ff));

   // Subtractive Euclid: each cycle subtract or swap, keeping r = t * a mod p
   always_comb begin
      run_in  = run_ff;
      r0_in   = r0_ff;
      r1_in   = r1_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
         r0_in  = modulus;
         t0_in  = '0;
         r1_in  = operand;
         t1_in  = W'(1);
      end else if (run_ff) begin
         if (r1_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            res_in  = (r0_ff == W'(1)) ? t0_ff : '0;
         end else if (r0_ff >= r1_ff) begin
            r0_in = r0_ff - r1_ff;
            t0_in = t_diff;
         end else begin
            r0_in = r1_ff;
            r1_in = r0_ff;
            t0_in = t1_ff;
            t1_in = t0_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

FILE: design/modular_prime_field_alu.sv
// Channel   Ports                                            Direction
// request   start, busy, req_opcode, req_operand_a/_b        in (busy out)
// response  rsp_valid, rsp_result                            out
// csr       csr_we, csr_wdata (modulus)                      in
//
// One item at a time; the receiver cannot stall. Both operands reduce bit-serially,
// then add, subtract, negate and equal strobe their result from S_EXEC. Multiply
// adds a shift-add pass in mpf_mul. Inverse adds its Euclid loop, one subtract or
// swap a cycle; divide runs inverse then multiply. Reset sets the modulus to 65521
// and idles the unit; busy is high from the accepted beat until the result beat.
module modular_prime_field_alu import mpf_pkg::*; #(
   parameter int WORD_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_opcode,
   input  logic [WORD_WIDTH-1:0] req_operand_a,
   input  logic [WORD_WIDTH-1:0] req_operand_b,
   output logic                  rsp_valid,
   output logic [WORD_WIDTH-1:0] rsp_result,
   input  logic                  csr_we,
   input  logic [WORD_WIDTH-1:0] csr_wdata
);

   localparam int W = WORD_WIDTH;
   localparam logic [W-1:0] MOD_INIT = W'(MOD_RESET);
   localparam logic [W-1:0] EFF_INIT = (MOD_INIT < W'(2)) ? W'(1) : MOD_INIT;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_EXEC,
      S_MUL,
      S_INV
   } state_type;

   state_type    state_ff;
   logic [W-1:0] eff_mod_ff;
   opcode_type   opcode_ff;
   logic [W-1:0] a_ff;
   logic [W-1:0] b_ff;
   logic         valid_ff;
   logic [W-1:0] result_ff;
   logic         mul_start_ff;
   logic [W-1:0] mul_x_ff;
   logic [W-1:0] mul_m_ff;
   logic         inv_start_ff;
   logic [W-1:0] inv_a_ff;

   logic         accept;
   logic         red_a_done, red_b_done;
   logic [W-1:0] red_a_result, red_b_result;
   logic         mul_done, inv_done;
   logic [W-1:0] mul_result, inv_result;
   logic [W-1:0] add_value, sub_value, neg_value;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Hold the effective modulus; anything below two acts as one
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_mod_ff <= EFF_INIT;
      end else if (csr_we) begin
         eff_mod_ff <= (csr_wdata < W'(2)) ? W'(1) : csr_wdata;
      end
   end

   mpf_reduce #(.W(W)) u_reduce_a (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .value   (req_operand_a),
      .modulus (eff_mod_ff),
      .done    (red_a_done),
      .result  (red_a_result)
   );

   mpf_reduce #(.W(W)) u_reduce_b (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .value   (req_operand_b),
      .modulus (eff_mod_ff),
      .done    (red_b_done),
      .result  (red_b_result)
   );

   mpf_mul #(.W(W)) u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start_ff),
      .multiplier   (mul_x_ff),
      .multiplicand (mul_m_ff),
      .modulus      (eff_mod_ff),
      .done         (mul_done),
      .result       (mul_result)
   );

   mpf_inv #(.W(W)) u_inv (
      .clock   (clock),
      .reset   (reset),
      .start   (inv_start_ff),
      .operand (inv_a_ff),
      .modulus (eff_mod_ff),
      .done    (inv_done),
      .result  (inv_result)
   );

   // Combinational operations on the reduced operands
   assign add_value = W'(fold((MAX_W+1)'(a_ff) + (MAX_W+1)'(b_ff),
                              (MAX_W+1)'(eff_mod_ff)));
   assign sub_value = (a_ff >= b_ff) ? a_ff - b_ff :
                      W'((W+1)'(a_ff) + (W+1)'(eff_mod_ff) - (W+1)'(b_ff));
   assign neg_value = (a_ff == '0) ? '0 : eff_mod_ff - a_ff;

   // Sequence one item: reduce, execute, then optional multiply, inverse, or inverse then multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= 1'b0;
         mul_start_ff <= 1'b0;
         inv_start_ff <= 1'b0;
      end else begin
         valid_ff     <= 1'b0;
         mul_start_ff <= 1'b0;
         inv_start_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  opcode_ff <= opcode_type'(req_opcode);
                  state_ff  <= S_REDUCE;
               end
            end
            S_REDUCE: begin
               if (red_a_done && red_b_done) begin
                  a_ff     <= red_a_result;
                  b_ff     <= red_b_result;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               case (opcode_ff)
                  OP_MULTIPLY: begin
                     mul_x_ff     <= b_ff;
                     mul_m_ff     <= a_ff;
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_MUL;
                  end
                  OP_DIVIDE: begin
                     inv_a_ff     <= b_ff;
                     inv_start_ff <= 1'b1;
                     state_ff     <= S_INV;
                  end
                  OP_INVERSE: begin
                     inv_a_ff     <= a_ff;
                     inv_start_ff <= 1'b1;
                     state_ff     <= S_INV;
                  end
                  OP_ADD: begin
                     result_ff <= add_value;
                     valid_ff  <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
                  OP_SUBTRACT: begin
                     result_ff <= sub_value;
                     valid_ff  <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
                  OP_NEGATE: begin
                     result_ff <= neg_value;
                     valid_ff  <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
                  OP_EQUAL: begin
                     result_ff <= (a_ff == b_ff) ? W'(1) : '0;
                     valid_ff  <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
                  default: begin
                     result_ff <= '0;
                     valid_ff  <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               endcase
            end
            S_INV: begin
               if (inv_done) begin
                  if (opcode_ff == OP_DIVIDE) begin
                     mul_x_ff     <= inv_result;
                     mul_m_ff     <= a_ff;
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_MUL;
                  end else begin
                     result_ff <= inv_result;
                     valid_ff  <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               end
            end
            S_MUL: begin
               if (mul_done) begin
                  result_ff <= mul_result;
                  valid_ff  <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule
